// ===== design/ppdc_pkg.sv =====
// Package for the PWM prescaler and period calculator.
// Holds field widths, opcodes, error codes and the divider handshake types.
// No dependencies.
package ppdc_pkg;

   localparam int CLK_KHZ_W   = 23;
   localparam int FREQ_W      = 20;
   localparam int DUTY_W      = 10;
   localparam int CHAN_W      = 3;
   localparam int SHIFT_W     = 3;
   localparam int COUNTER_W   = 16;
   localparam int COMPARE_W   = 17;
   localparam int PRODUCT_W   = 27;
   localparam int DIVIDEND_W  = 32;
   localparam int DIVISOR_W   = 20;
   localparam int BITLEN_W    = 5;
   localparam int RECIP_W      = 27;
   localparam int RECIP_PROD_W = PRODUCT_W + RECIP_W;
   localparam int RECIP_SHIFT  = 36;

   localparam logic [9:0]  HZ_PER_KHZ = 10'd1000;
   localparam logic [9:0]  DUTY_SCALE = 10'd1000;
   localparam logic [4:0]  MAX_SHIFT  = 5'd7;

   // The rounded-up value of 2^36 / 1000 gives an exact quotient for every duty product.
   localparam logic [RECIP_W-1:0] DUTY_RECIP = 27'd68719477;

   localparam logic [1:0] OP_SET_FREQ = 2'd0;
   localparam logic [1:0] OP_SET_DUTY = 2'd1;
   localparam logic [1:0] OP_SET_BOTH = 2'd2;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_ZERO_FREQ = 2'd1;
   localparam logic [1:0] ERR_PRESCALE  = 2'd2;
   localparam logic [1:0] ERR_NO_FREQ   = 2'd3;

   typedef struct packed {
      logic                    start;
      logic [DIVIDEND_W-1:0]   dividend;
      logic [DIVISOR_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic [DIVIDEND_W-1:0]   quotient;
   } div_rsp_type;

endpackage

// ===== design/ppdc_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Uses ppdc_pkg for widths and the request and response structs.
module ppdc_div
   import ppdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  divisor_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  active_ff;
   logic                  done_ff;

   logic [DIVISOR_W:0]    trial;
   logic                  fits;
   logic [DIVISOR_W:0]    diff;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits  = trial >= {1'b0, divisor_ff};
      diff  = trial - {1'b0, divisor_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            rem_ff     <= '0;
            quo_ff     <= div_req.dividend;
            divisor_ff <= div_req.divisor;
            cnt_ff     <= '0;
            active_ff  <= 1'b1;
         end else if (active_ff) begin
            rem_ff <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== design/pwm_prescale_period_duty_calc_top.sv =====
// PWM prescaler, period and compare calculator, top level; uses ppdc_pkg and ppdc_div.
// Set frequency runs the clock multiply and two divisions, set duty the duty multiply and scale,
// set both all of these; a prescaler error ends after the first division, other errors go straight to the result.
// Each division runs the 32-step serial divider; duty scaling is a multiply.
// One item is in flight at a time; the next is accepted the cycle after the result is taken.
// Reset is synchronous: clock_khz returns to 20000 and no frequency is stored.
module pwm_prescale_period_duty_calc_top
   import ppdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [22:0] csr_data,   // clock_khz
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // channel, frequency_hz, duty_permille, zero fill
   input  logic [1:0]  req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // prescale_shift, period_count, compare_value, out_channel
   output logic [3:0]  rsp_tuser   // period_written, compare_written, error_code
);

   typedef enum logic [3:0] {
      S_IDLE, S_CLK_MUL, S_Q_START, S_Q_WAIT, S_P_START, S_P_WAIT,
      S_DUTY_MUL, S_C_SCALE, S_RESULT
   } state_type;

   state_type              state_ff, state_in;
   logic [CLK_KHZ_W-1:0]   clock_khz_ff, clock_khz_in;
   logic [1:0]             opcode_ff, opcode_in;
   logic [CHAN_W-1:0]      channel_ff, channel_in;
   logic [FREQ_W-1:0]      freq_ff, freq_in;
   logic [DUTY_W-1:0]      duty_ff, duty_in;
   logic [DIVIDEND_W-1:0]  clk_hz_ff, clk_hz_in;
   logic [SHIFT_W-1:0]     shift_ff, shift_in;
   logic [COUNTER_W-1:0]   period_ff, period_in;
   logic [COMPARE_W-1:0]   compare_ff, compare_in;
   logic                   pw_ff, pw_in;
   logic                   cw_ff, cw_in;
   logic [1:0]             err_ff, err_in;
   logic [PRODUCT_W-1:0]   product_ff, product_in;
   logic [COUNTER_W-1:0]   stored_period_ff, stored_period_in;
   logic                   freq_valid_ff, freq_valid_in;

   logic [32:0]            clk_prod_wide;
   logic [RECIP_PROD_W-1:0] recip_prod;
   logic [DUTY_W-1:0]      duty_sat;
   logic [BITLEN_W-1:0]    bitlen;
   logic [FREQ_W-1:0]      req_freq;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   ppdc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      clk_prod_wide = 33'(clock_khz_ff) * 33'(HZ_PER_KHZ);
      recip_prod    = RECIP_PROD_W'(product_ff) * RECIP_PROD_W'(DUTY_RECIP);
      duty_sat      = (duty_ff > DUTY_SCALE) ? DUTY_SCALE : duty_ff;
      bitlen        = '0;
      for (int i = 0; i < COUNTER_W; i++) begin
         if (div_rsp.quotient[i]) bitlen = BITLEN_W'(i + 1);
      end
      req_freq = req_tdata[22:3];
   end

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = freq_ff;
      unique case (state_ff)
         S_Q_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = {16'd0, clk_hz_ff[31:16]};
         end
         S_P_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = clk_hz_ff >> shift_ff;
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in         = state_ff;
      clock_khz_in     = clock_khz_ff;
      opcode_in        = opcode_ff;
      channel_in       = channel_ff;
      freq_in          = freq_ff;
      duty_in          = duty_ff;
      clk_hz_in        = clk_hz_ff;
      shift_in         = shift_ff;
      period_in        = period_ff;
      compare_in       = compare_ff;
      pw_in            = pw_ff;
      cw_in            = cw_ff;
      err_in           = err_ff;
      product_in       = product_ff;
      stored_period_in = stored_period_ff;
      freq_valid_in    = freq_valid_ff;

      if (csr_valid) clock_khz_in = csr_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               opcode_in  = req_tuser;
               channel_in = req_tdata[2:0];
               freq_in    = req_freq;
               duty_in    = req_tdata[32:23];
               shift_in   = '0;
               period_in  = '0;
               compare_in = '0;
               pw_in      = 1'b0;
               cw_in      = 1'b0;
               err_in     = ERR_NONE;
               unique case (req_tuser) inside
                  OP_SET_FREQ, OP_SET_BOTH: begin
                     if (req_freq == '0) begin
                        err_in   = ERR_ZERO_FREQ;
                        state_in = S_RESULT;
                     end else begin
                        state_in = S_CLK_MUL;
                     end
                  end
                  OP_SET_DUTY: begin
                     if (freq_valid_ff) begin
                        state_in = S_DUTY_MUL;
                     end else begin
                        err_in   = ERR_NO_FREQ;
                        state_in = S_RESULT;
                     end
                  end
                  default: begin
                     state_in = S_RESULT;
                  end
               endcase
            end
         end
         S_CLK_MUL: begin
            clk_hz_in = clk_prod_wide[31:0];
            state_in  = S_Q_START;
         end
         S_Q_START: begin
            state_in = S_Q_WAIT;
         end
         S_Q_WAIT: begin
            if (div_rsp.done) begin
               if (bitlen > MAX_SHIFT) begin
                  err_in   = ERR_PRESCALE;
                  state_in = S_RESULT;
               end else begin
                  shift_in = bitlen[SHIFT_W-1:0];
                  state_in = S_P_START;
               end
            end
         end
         S_P_START: begin
            state_in = S_P_WAIT;
         end
         S_P_WAIT: begin
            if (div_rsp.done) begin
               period_in        = div_rsp.quotient[COUNTER_W-1:0];
               stored_period_in = div_rsp.quotient[COUNTER_W-1:0];
               freq_valid_in    = 1'b1;
               pw_in            = 1'b1;
               state_in         = (opcode_ff == OP_SET_BOTH) ? S_DUTY_MUL : S_RESULT;
            end
         end
         S_DUTY_MUL: begin
            product_in = PRODUCT_W'(duty_sat) *
                         PRODUCT_W'({1'b0, stored_period_ff} + 17'd1);
            state_in   = S_C_SCALE;
         end
         S_C_SCALE: begin
            compare_in = recip_prod[RECIP_SHIFT +: COMPARE_W];
            cw_in      = 1'b1;
            state_in   = S_RESULT;
         end
         S_RESULT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         clock_khz_ff     <= CLK_KHZ_W'(20000);
         stored_period_ff <= '0;
         freq_valid_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clock_khz_ff     <= clock_khz_in;
         stored_period_ff <= stored_period_in;
         freq_valid_ff    <= freq_valid_in;
      end
      opcode_ff  <= opcode_in;
      channel_ff <= channel_in;
      freq_ff    <= freq_in;
      duty_ff    <= duty_in;
      clk_hz_ff  <= clk_hz_in;
      shift_ff   <= shift_in;
      period_ff  <= period_in;
      compare_ff <= compare_in;
      pw_ff      <= pw_in;
      cw_ff      <= cw_in;
      err_ff     <= err_in;
      product_ff <= product_in;
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESULT);
   assign rsp_tdata  = {1'b0, channel_ff, compare_ff, period_ff, shift_ff};
   assign rsp_tuser  = {err_ff, cw_ff, pw_ff};

   // An accepted item keeps the block busy until its result is taken.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted again right after an item");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a result is pending");

   a_written_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (pw_ff || cw_ff) |-> err_ff == ERR_NONE)
      else $error("update flagged together with an error");

   a_compare_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && cw_ff |-> compare_ff <= 17'd65536 && freq_valid_ff)
      else $error("compare value out of range or without a frequency");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pwm_prescale_period_duty_calc_top: drives requests on the stream ports and clock
// settings on the csr port, and predicts every result. Depends on ppdc_pkg and the RTL only.
module testbench;
   import ppdc_pkg::*;

   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 1500000;
   localparam int unsigned PHASE_ITEMS = 185;
   localparam int unsigned PHASES = 10;
   localparam int unsigned QUIET_FROM = 1650;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [CHAN_W-1:0]   channel;
      logic [FREQ_W-1:0]   frequency_hz;
      logic [DUTY_W-1:0]   duty_permille;
   } pwm_request_type;

   typedef struct {
      logic [SHIFT_W-1:0]   prescale_shift;
      logic [COUNTER_W-1:0] period_count;
      logic [COMPARE_W-1:0] compare_value;
      logic [CHAN_W-1:0]    out_channel;
      logic                 period_written;
      logic                 compare_written;
      logic [1:0]           error_code;
   } timer_setting_type;

   class timer_setting_scoreboard;
      logic [CLK_KHZ_W-1:0] clock_khz;
      logic [COUNTER_W-1:0] stored_period;
      bit                   frequency_valid;
      timer_setting_type    pending_settings[$];
      int unsigned          error_count;

      function new();
         clock_khz = 23'd20000;
         stored_period = '0;
         frequency_valid = 1'b0;
         error_count = 0;
      endfunction

      function timer_setting_type timer_settings_for(pwm_request_type r);
         timer_setting_type s;
         logic [31:0] clk_hz;
         logic [31:0] quot;
         logic [31:0] per;
         logic [63:0] duty;
         logic [63:0] cmp;
         int unsigned shift;
         s.prescale_shift = '0;
         s.period_count = '0;
         s.compare_value = '0;
         s.out_channel = r.channel;
         s.period_written = 1'b0;
         s.compare_written = 1'b0;
         s.error_code = ERR_NONE;
         if (r.opcode == OP_SET_FREQ || r.opcode == OP_SET_BOTH) begin
            if (r.frequency_hz == '0) begin
               s.error_code = ERR_ZERO_FREQ;
            end else begin
               clk_hz = {9'b0, clock_khz} * 32'd1000;
               quot = (clk_hz >> 16) / {12'b0, r.frequency_hz};
               shift = 0;
               while (shift < 32 && (quot >> shift) != 0) shift++;
               if (shift > MAX_SHIFT) begin
                  s.error_code = ERR_PRESCALE;
               end else begin
                  per = (clk_hz >> shift) / {12'b0, r.frequency_hz};
                  stored_period = per[COUNTER_W-1:0];
                  frequency_valid = 1'b1;
                  s.prescale_shift = shift[SHIFT_W-1:0];
                  s.period_count = per[COUNTER_W-1:0];
                  s.period_written = 1'b1;
               end
            end
         end
         if (s.error_code == ERR_NONE && (r.opcode == OP_SET_DUTY || r.opcode == OP_SET_BOTH))
         begin
            if (!frequency_valid) begin
               s.error_code = ERR_NO_FREQ;
            end else begin
               duty = (r.duty_permille > DUTY_SCALE) ? 64'd1000 : {54'b0, r.duty_permille};
               cmp = (duty * ({48'b0, stored_period} + 64'd1)) / 64'd1000;
               s.compare_value = cmp[COMPARE_W-1:0];
               s.compare_written = 1'b1;
            end
         end
         return s;
      endfunction

      function void note_request(pwm_request_type r);
         pending_settings.push_back(timer_settings_for(r));
      endfunction

      function void check_field(string name, longint unsigned exp_val, longint unsigned act_val);
         if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            error_count++;
         end
      endfunction

      function void check_result(timer_setting_type got);
         timer_setting_type want;
         if (pending_settings.size() == 0) begin
            $error("result item arrived with no request outstanding");
            error_count++;
            return;
         end
         want = pending_settings.pop_front();
         check_field("prescale_shift", want.prescale_shift, got.prescale_shift);
         check_field("period_count", want.period_count, got.period_count);
         check_field("compare_value", want.compare_value, got.compare_value);
         check_field("out_channel", want.out_channel, got.out_channel);
         check_field("period_written", want.period_written, got.period_written);
         check_field("compare_written", want.compare_written, got.compare_written);
         check_field("error_code", want.error_code, got.error_code);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [22:0] csr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [3:0]  rsp_tuser;

   timer_setting_scoreboard board = new();
   bit quiet_tail = 1'b0;
   int unsigned cycle_count = 0;

   pwm_prescale_period_duty_calc_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      timer_setting_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.prescale_shift = rsp_tdata[2:0];
         got.period_count = rsp_tdata[18:3];
         got.compare_value = rsp_tdata[35:19];
         got.out_channel = rsp_tdata[38:36];
         got.period_written = rsp_tuser[0];
         got.compare_written = rsp_tuser[1];
         got.error_code = rsp_tuser[3:2];
         board.check_result(got);
      end
   end

   // The result side takes items in runs of random length, with random stalls until the quiet tail.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 7) == 0) repeat ($urandom_range(100, 300)) @(negedge clock);
         else repeat ($urandom_range(0, 30)) @(negedge clock);
         if (!quiet_tail && $urandom_range(0, 2) != 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge clock);
         end
      end
   end

   task automatic send_request(input pwm_request_type r);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= r.opcode;
      req_tdata <= {7'b0, r.duty_permille, r.frequency_hz, r.channel};
      do @(posedge clock); while (!req_tready);
      board.note_request(r);
   endtask

   task automatic hold_requests(input int unsigned cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_with_gap(input pwm_request_type r);
      send_request(r);
      if (!quiet_tail && $urandom_range(0, 9) < 3) hold_requests($urandom_range(1, 15));
   endtask

   task automatic write_clock_khz(input logic [22:0] value);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending_settings.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.clock_khz = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic pwm_request_type make_request(logic [1:0] op, int unsigned ch,
                                                    int unsigned freq, int unsigned duty);
      pwm_request_type r;
      r.opcode = op;
      r.channel = ch[CHAN_W-1:0];
      r.frequency_hz = freq[FREQ_W-1:0];
      r.duty_permille = duty[DUTY_W-1:0];
      return r;
   endfunction

   // Mostly frequencies of 512 Hz and up, which give a legal prescaler for any clock,
   // and now and then any width from zero up to get the error paths.
   function automatic pwm_request_type random_request();
      int unsigned pick;
      int unsigned bits;
      int unsigned freq;
      logic [1:0] op;
      pick = $urandom_range(0, 99);
      op = (pick < 35) ? OP_SET_FREQ : (pick < 70) ? OP_SET_DUTY :
           (pick < 92) ? OP_SET_BOTH : OP_NONE;
      bits = ($urandom_range(0, 4) != 0) ? $urandom_range(10, 20) : $urandom_range(0, 20);
      freq = (bits == 0) ? 0 : $urandom_range((1 << (bits - 1)), (1 << bits) - 1);
      return make_request(op, $urandom_range(0, 7), freq, $urandom_range(0, 1023));
   endfunction

   initial begin
      logic [22:0] clock_plan[PHASES-1];
      pwm_request_type directed[$];
      int unsigned sent;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_SET_FREQ;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed.push_back(make_request(OP_SET_DUTY, 0, 0, 500));
      directed.push_back(make_request(OP_SET_FREQ, 1, 0, 0));
      directed.push_back(make_request(OP_SET_BOTH, 2, 0, 1023));
      directed.push_back(make_request(OP_SET_FREQ, 3, 1, 0));
      directed.push_back(make_request(OP_SET_BOTH, 4, 2, 10));
      directed.push_back(make_request(OP_SET_DUTY, 5, 0, 1000));
      directed.push_back(make_request(OP_SET_FREQ, 7, 1000, 0));
      directed.push_back(make_request(OP_SET_DUTY, 0, 0, 0));
      directed.push_back(make_request(OP_SET_DUTY, 1, 0, 1));
      directed.push_back(make_request(OP_SET_DUTY, 2, 0, 999));
      directed.push_back(make_request(OP_SET_DUTY, 3, 0, 1000));
      directed.push_back(make_request(OP_SET_DUTY, 4, 0, 1023));
      directed.push_back(make_request(OP_SET_BOTH, 5, 1048575, 1023));
      directed.push_back(make_request(OP_SET_FREQ, 6, 1000000, 0));
      directed.push_back(make_request(OP_SET_BOTH, 7, 3, 500));
      directed.push_back(make_request(OP_SET_FREQ, 0, 0, 0));
      directed.push_back(make_request(OP_SET_DUTY, 1, 0, 500));
      directed.push_back(make_request(OP_NONE, 3, 0, 1023));
      directed.push_back(make_request(OP_NONE, 7, 1048575, 1023));
      directed.push_back(make_request(OP_SET_DUTY, 6, 1048575, 512));
      foreach (directed[i]) send_with_gap(directed[i]);

      clock_plan[0] = 23'd1;
      clock_plan[1] = 23'd8388607;
      clock_plan[2] = 23'd4294967;
      clock_plan[3] = 23'd4294968;
      clock_plan[4] = 23'd0;
      clock_plan[5] = 23'($urandom_range(1, 8388607));
      clock_plan[6] = 23'd20000;
      clock_plan[7] = 23'($urandom_range(1, 8388607));
      clock_plan[8] = 23'($urandom_range(1000, 200000));

      sent = 0;
      for (int unsigned p = 0; p < PHASES; p++) begin
         if (p > 0) write_clock_khz(clock_plan[p-1]);
         for (int unsigned j = 0; j < PHASE_ITEMS; j++) begin
            if (sent >= QUIET_FROM) quiet_tail = 1'b1;
            send_with_gap(random_request());
            sent++;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending_settings.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (board.error_count == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end

endmodule
